@@ hdl/lkvc_pkg.sv @@
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [VAL_W-1:0] val_t;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    localparam val_t MISS_VALUE  = {VAL_W{1'b1}};
    localparam val_t WRITE_VALUE = {VAL_W{1'b0}};

endpackage

`default_nettype wire

@@ hdl/lkvc_ram.sv @@
`default_nettype none

module lkvc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              wen,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/lru_key_value_cache.sv @@
// Item flow: a lookup miss makes one read sweep of the entry memory to match the key; a
// hit or any write makes that sweep and then a read-modify-write sweep to age the recency
// ranks. The next request is taken in the cycle after the result is registered, so a new
// request is not taken until the last one is through. A result may wait at the output.
// Reset clears valid bits, occupancy and the output; capacity returns to 16; no clearing pass.
`default_nettype none

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wen,
    input  wire logic [4:0]  cfg_wdata,   // capacity
    // requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,     // [31:0] key, [63:32] value
    input  wire logic        s_tuser,     // operation: 0 lookup, 1 write
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,     // read_value
    output logic             m_tuser      // found
);

    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RW   = IW;
    localparam int OW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (OW > lkvc_pkg::CAP_W) ? OW : lkvc_pkg::CAP_W;
    localparam int MW   = lkvc_pkg::KEY_W + lkvc_pkg::VAL_W + RW;

    localparam logic [OW-1:0]   N_CNT    = OW'(MAX_ENTRIES);
    localparam logic [IW-1:0]   LAST_IDX = IW'(MAX_ENTRIES - 1);
    localparam logic [CMPW-1:0] N_CMP    = CMPW'(MAX_ENTRIES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_PLAN = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [lkvc_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [OW-1:0]          occ_reg, occ_next;
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;

    logic                   op_reg, op_next;
    lkvc_pkg::key_t         key_reg, key_next;
    lkvc_pkg::val_t         val_reg, val_next;

    logic [OW-1:0]          cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [IW-1:0]          pidx_reg, pidx_next;

    logic                   hit_reg, hit_next;
    logic [IW-1:0]          hit_idx_reg, hit_idx_next;
    lkvc_pkg::val_t         hit_val_reg, hit_val_next;
    logic [RW-1:0]          hit_rank_reg, hit_rank_next;
    logic                   old_any_reg, old_any_next;
    logic [IW-1:0]          old_idx_reg, old_idx_next;
    logic [RW-1:0]          old_rank_reg, old_rank_next;
    logic                   free_any_reg, free_any_next;
    logic [IW-1:0]          free_idx_reg, free_idx_next;

    logic [IW-1:0]          slot_reg, slot_next;
    logic [RW-1:0]          touch_rank_reg, touch_rank_next;

    logic                   res_found_reg, res_found_next;
    lkvc_pkg::val_t         res_val_reg, res_val_next;

    logic                   mv_reg, mv_next;
    logic                   mfound_reg, mfound_next;
    lkvc_pkg::val_t         mval_reg, mval_next;

    // entry memory
    logic                   ram_wen;
    logic [IW-1:0]          ram_waddr;
    logic [MW-1:0]          ram_wdata;
    logic [IW-1:0]          ram_raddr;
    logic [MW-1:0]          ram_rdata;

    lkvc_pkg::key_t         rd_key;
    lkvc_pkg::val_t         rd_val;
    logic [RW-1:0]          rd_rank;
    logic                   rd_valid;
    logic [CMPW-1:0]        eff_cap;
    logic [CMPW-1:0]        cap_ext;

    lkvc_ram #(
        .DATA_W(MW),
        .DEPTH (MAX_ENTRIES),
        .ADDR_W(IW)
    ) u_ram (
        .aclk (aclk),
        .wen  (ram_wen),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_rank  = ram_rdata[RW-1:0];
    assign rd_val   = ram_rdata[RW +: lkvc_pkg::VAL_W];
    assign rd_key   = ram_rdata[RW + lkvc_pkg::VAL_W +: lkvc_pkg::KEY_W];
    assign rd_valid = valid_reg[pidx_reg];

    assign ram_raddr = (cnt_reg < N_CNT) ? cnt_reg[IW-1:0] : '0;

    assign cap_ext = CMPW'(cap_reg);
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CMPW'(1);
        end else if (cap_ext > N_CMP) begin
            eff_cap = N_CMP;
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tuser  = mfound_reg;
    assign m_tdata  = mval_reg;

    always_comb begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        occ_next        = occ_reg;
        valid_next      = valid_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_val_next    = hit_val_reg;
        hit_rank_next   = hit_rank_reg;
        old_any_next    = old_any_reg;
        old_idx_next    = old_idx_reg;
        old_rank_next   = old_rank_reg;
        free_any_next   = free_any_reg;
        free_idx_next   = free_idx_reg;
        slot_next       = slot_reg;
        touch_rank_next = touch_rank_reg;
        res_found_next  = res_found_reg;
        res_val_next    = res_val_reg;
        mv_next         = mv_reg;
        mfound_next     = mfound_reg;
        mval_next       = mval_reg;
        ram_wen         = 1'b0;
        ram_waddr       = pidx_reg;
        ram_wdata       = ram_rdata;

        if (cfg_wen) begin
            cap_next = cfg_wdata;
        end

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        // read address sweep shared by SCAN and UPD
        if ((state_reg == ST_SCAN) || (state_reg == ST_UPD)) begin
            if (cnt_reg < N_CNT) begin
                pend_next = 1'b1;
                pidx_next = cnt_reg[IW-1:0];
                cnt_next  = cnt_reg + OW'(1);
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next       = s_tuser;
                    key_next      = s_tdata[31:0];
                    val_next      = s_tdata[63:32];
                    cnt_next      = '0;
                    hit_next      = 1'b0;
                    old_any_next  = 1'b0;
                    free_any_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (pend_reg) begin
                    if (rd_valid && (rd_key == key_reg) && !hit_reg) begin
                        hit_next      = 1'b1;
                        hit_idx_next  = pidx_reg;
                        hit_val_next  = rd_val;
                        hit_rank_next = rd_rank;
                    end
                    if (rd_valid && (!old_any_reg || (rd_rank > old_rank_reg))) begin
                        old_any_next  = 1'b1;
                        old_idx_next  = pidx_reg;
                        old_rank_next = rd_rank;
                    end
                    if (!rd_valid && !free_any_reg) begin
                        free_any_next = 1'b1;
                        free_idx_next = pidx_reg;
                    end
                    if (pidx_reg == LAST_IDX) begin
                        state_next = ST_PLAN;
                    end
                end
            end
            ST_PLAN: begin
                cnt_next       = '0;
                res_found_next = hit_reg;
                state_next     = ST_UPD;
                if (op_reg == lkvc_pkg::OP_LOOKUP) begin
                    res_val_next    = hit_reg ? hit_val_reg : lkvc_pkg::MISS_VALUE;
                    slot_next       = hit_idx_reg;
                    touch_rank_next = hit_rank_reg;
                    if (!hit_reg) begin
                        state_next = ST_DONE;
                    end
                end else begin
                    res_val_next = lkvc_pkg::WRITE_VALUE;
                    if (hit_reg) begin
                        slot_next       = hit_idx_reg;
                        touch_rank_next = hit_rank_reg;
                    end else if ((CMPW'(occ_reg) < eff_cap) && free_any_reg) begin
                        // new entry starts as the oldest, then moves to the front
                        slot_next                = free_idx_reg;
                        touch_rank_next          = occ_reg[RW-1:0];
                        valid_next[free_idx_reg] = 1'b1;
                        occ_next                 = occ_reg + OW'(1);
                    end else begin
                        slot_next       = old_idx_reg;
                        touch_rank_next = old_rank_reg;
                    end
                end
            end
            ST_UPD: begin
                if (pend_reg) begin
                    if (pidx_reg == slot_reg) begin
                        ram_wen   = 1'b1;
                        ram_wdata = {key_reg,
                                     (op_reg == lkvc_pkg::OP_WRITE) ? val_reg : rd_val,
                                     {RW{1'b0}}};
                    end else if (rd_valid && (rd_rank < touch_rank_reg)) begin
                        ram_wen   = 1'b1;
                        ram_wdata = {rd_key, rd_val, rd_rank + RW'(1)};
                    end
                    if (pidx_reg == LAST_IDX) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next     = 1'b1;
                    mfound_next = res_found_reg;
                    mval_next   = res_val_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cap_reg   <= lkvc_pkg::CAP_RESET;
            occ_reg   <= '0;
            valid_reg <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            occ_reg   <= occ_next;
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        cnt_reg        <= cnt_next;
        pidx_reg       <= pidx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_val_reg    <= hit_val_next;
        hit_rank_reg   <= hit_rank_next;
        old_any_reg    <= old_any_next;
        old_idx_reg    <= old_idx_next;
        old_rank_reg   <= old_rank_next;
        free_any_reg   <= free_any_next;
        free_idx_reg   <= free_idx_next;
        slot_reg       <= slot_next;
        touch_rank_reg <= touch_rank_next;
        res_found_reg  <= res_found_next;
        res_val_reg    <= res_val_next;
        mfound_reg     <= mfound_next;
        mval_reg       <= mval_next;
    end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
module tb;

    localparam int SLOTS     = 16;
    localparam int LONG_HOLD = 300;
    localparam int LIMIT     = 1000000;
    localparam int POOL_MAX  = 24;

    typedef struct packed {
        logic op;
        lkvc_pkg::key_t key;
        lkvc_pkg::val_t value;
    } request_t;

    typedef struct packed {
        logic found;
        lkvc_pkg::val_t value;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wen = 1'b0;
    logic [4:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic m_tuser;

    lru_key_value_cache uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [31:0] key, [63:32] value
        .s_tuser   (s_tuser),     // operation
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // read_value
        .m_tuser   (m_tuser)      // found
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // cache shadow
    lkvc_pkg::key_t slot_key  [SLOTS];
    lkvc_pkg::val_t slot_val  [SLOTS];
    bit             slot_used [SLOTS];
    int unsigned    slot_age  [SLOTS];
    int unsigned    fill;
    logic [4:0]     cap_reg;

    request_t pending_reqs[$];
    answer_t  expected_answers[$];

    int send_gap_max;
    int recv_stall_max;
    int gap_left;
    int stall_left;
    int hold_left;
    int holds_wanted;
    int holds_done;
    int accepted;
    int checked;
    int cfg_writes;
    int hits_seen;
    int mismatches;
    int cycles;

    function automatic void make_newest(int s);
        int unsigned prev;
        prev = slot_age[s];
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && i != s && slot_age[i] < prev)
                slot_age[i]++;
        end
        slot_age[s] = 0;
    endfunction

    function automatic answer_t cache_apply(logic op, lkvc_pkg::key_t k, lkvc_pkg::val_t v);
        answer_t r;
        int hit;
        int slot;
        int unsigned lim;
        hit = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && slot_used[i] && slot_key[i] == k)
                hit = i;
        end
        r.found = (hit >= 0);
        if (op == lkvc_pkg::OP_LOOKUP) begin
            if (hit >= 0) begin
                r.value = slot_val[hit];
                make_newest(hit);
            end else begin
                r.value = lkvc_pkg::MISS_VALUE;
            end
            return r;
        end
        r.value = lkvc_pkg::WRITE_VALUE;
        if (hit >= 0) begin
            slot_val[hit] = v;
            make_newest(hit);
            return r;
        end
        lim = (cap_reg == 0) ? 1 : (cap_reg > SLOTS) ? SLOTS : cap_reg;
        slot = -1;
        if (fill < lim) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (slot < 0 && !slot_used[i])
                    slot = i;
            end
            if (slot >= 0) begin
                // new entry starts as the oldest, then gets promoted
                slot_used[slot] = 1'b1;
                slot_age[slot] = fill;
                fill++;
            end
        end
        if (slot < 0) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_used[i] && (slot < 0 || slot_age[i] > slot_age[slot]))
                    slot = i;
            end
        end
        slot_key[slot] = k;
        slot_val[slot] = v;
        make_newest(slot);
        return r;
    endfunction

    // request driver
    always @(posedge aclk) begin
        request_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_answers.push_back(cache_apply(s_tuser, s_tdata[31:0], s_tdata[63:32]));
                accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    req = pending_reqs.pop_front();
                    s_tdata <= {req.value, req.key};
                    s_tuser <= req.op;
                    s_tvalid <= 1'b1;
                    gap_left = $urandom_range(0, send_gap_max);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    $error("unexpected result: found %b read_value %h", m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_answers.pop_front();
                    checked++;
                    if (want.found)
                        hits_seen++;
                    if (m_tuser !== want.found) begin
                        $error("found: expected %b, got %b", want.found, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata !== want.value) begin
                        $error("read_value: expected %h, got %h", want.value, m_tdata);
                        mismatches++;
                    end
                end
                stall_left = $urandom_range(0, recv_stall_max);
            end
            if (hold_left == 0 && holds_done < holds_wanted) begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic push_req(logic op, lkvc_pkg::key_t k, lkvc_pkg::val_t v);
        request_t r;
        r.op = op;
        r.key = k;
        r.value = v;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_capacity(logic [4:0] c);
        wait_idle();
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= c;
        cap_reg = c;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        cfg_writes++;
        @(negedge aclk);
    endtask

    task automatic random_phase(int n, logic [4:0] c, int gmax, int smax, bit long_hold);
        lkvc_pkg::key_t pool[POOL_MAX];
        int pool_n;
        int eff;
        lkvc_pkg::key_t k;
        set_capacity(c);
        send_gap_max = gmax;
        recv_stall_max = smax;
        if (long_hold)
            holds_wanted++;
        eff = (c == 0) ? 1 : (c > SLOTS) ? SLOTS : c;
        // working set from the capacity up to 8 keys above it (at most 24): hits and evictions both
        pool_n = eff + $urandom_range(0, 8);
        if (pool_n > POOL_MAX)
            pool_n = POOL_MAX;
        for (int i = 0; i < POOL_MAX; i++)
            pool[i] = $urandom;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                k = $urandom;
            else
                k = pool[$urandom_range(0, pool_n - 1)];
            push_req($urandom_range(0, 1) ? lkvc_pkg::OP_WRITE : lkvc_pkg::OP_LOOKUP,
                     k, $urandom);
        end
    endtask

    initial begin
        logic [4:0] caps[10];
        caps = '{5'd16, 5'd1, 5'd8, 5'd31, 5'd0, 5'd4, 5'd17, 5'd3, 5'd12, 5'd2};
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_age[i] = 0;
        end
        fill = 0;
        cap_reg = lkvc_pkg::CAP_RESET;
        send_gap_max = 10;
        recv_stall_max = 10;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty cache, extreme keys and values, hit on lookup and write
        push_req(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0);
        push_req(lkvc_pkg::OP_WRITE,  32'h0000_0000, 32'h7FFF_FFFF);
        push_req(lkvc_pkg::OP_WRITE,  32'hFFFF_FFFF, 32'h8000_0000);
        push_req(lkvc_pkg::OP_WRITE,  32'h8000_0000, 32'hFFFF_FFFF);
        push_req(lkvc_pkg::OP_WRITE,  32'h7FFF_FFFF, 32'h0000_0000);
        push_req(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        push_req(lkvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        push_req(lkvc_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0);
        push_req(lkvc_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'h0);
        push_req(lkvc_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0);
        push_req(lkvc_pkg::OP_WRITE,  32'h0000_0000, 32'h1234_5678);
        push_req(lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0);

        // zero capacity acts as one, below current occupancy: every miss evicts
        set_capacity(5'd0);
        push_req(lkvc_pkg::OP_WRITE,  32'h0000_0005, 32'hA5A5_A5A5);
        push_req(lkvc_pkg::OP_WRITE,  32'h0000_0006, 32'h5A5A_5A5A);
        push_req(lkvc_pkg::OP_LOOKUP, 32'h0000_0005, 32'h0);
        push_req(lkvc_pkg::OP_LOOKUP, 32'h0000_0006, 32'h0);
        push_req(lkvc_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0);

        // capacity above the slot count saturates
        set_capacity(5'd31);
        for (int i = 0; i < 6; i++)
            push_req(lkvc_pkg::OP_WRITE, 32'h100 + i, $urandom);
        push_req(lkvc_pkg::OP_LOOKUP, 32'h0000_0105, 32'h0);

        for (int p = 0; p < 10; p++)
            random_phase(153, caps[p], (p % 3 == 1) ? 0 : 10, (p % 4 == 2) ? 0 : 10,
                         p == 2 || p == 6);

        wait_idle();
        repeat (2 * SLOTS + 8) @(posedge aclk);
        if (expected_answers.size() != 0) begin
            $error("%0d results never arrived", expected_answers.size());
            mismatches++;
        end
        $display("%0d requests sent, %0d results checked (%0d found)", accepted, checked,
                 hits_seen);
        $display("%0d capacity settings, %0d long output stalls", cfg_writes, holds_done);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/lkvc_pkg.sv
hdl/lkvc_ram.sv
hdl/lru_key_value_cache.sv
tb/sv/tb.sv
